>>> rtl/core/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared constants, codes and control types for the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

    // Store geometry
    localparam int STORE_BYTES = 65536;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    // Gap pointers must reach STORE_BYTES itself
    localparam int PTR_W       = ADDR_W + 1;
    // Width used for position and length compares (position is 16 bits)
    localparam int CMP_W       = (PTR_W > 17) ? PTR_W : 17;

    // Field widths
    localparam int ACT_W  = 2;
    localparam int POS_W  = 16;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int STS_W  = 2;

    // Request actions
    localparam logic [ACT_W-1:0] ACT_READ      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_BACKSPACE = 2'd3;

    // Result status codes
    localparam logic [STS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STS_W-1:0] ST_NO_ROOM = 2'd1;
    localparam logic [STS_W-1:0] ST_RANGE   = 2'd2;

    // An insert needs at least this many free gap slots
    localparam logic [PTR_W-1:0] MIN_FREE_SLOTS = PTR_W'(2);

    // Largest reported text length
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Controller to datapath commands
    typedef struct packed {
        logic take_req;  // latch the input word
        logic eval;      // latch the status of the request
        logic do_read;   // issue the text read
        logic step;      // move the gap by one byte
        logic do_edit;   // apply insert / delete / backspace
        logic load_out;  // load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [STS_W-1:0] code;     // status of the latched request
        logic             is_read;  // latched request is a read
        logic             at_pos;   // gap begins at the request position
        logic             wr_pend;  // a gap copy write is still in flight
        logic             out_busy; // result register cannot take a word
    } t_sts;

endpackage

>>> rtl/core/gbts_if.sv
// ----------------------------------------------------------------------------
// gbts_if
// Valid/ready channels for request and response words of the text store.
// ----------------------------------------------------------------------------
interface gbts_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [gbts_pkg::ACT_W-1:0]            action;
    logic [gbts_pkg::POS_W-1:0]            position;
    logic [gbts_pkg::BYTE_W-1:0]           new_byte;

    modport source (output valid, output action, output position, output new_byte,
                    input ready);
    modport sink   (input valid, input action, input position, input new_byte,
                    output ready);
endinterface

interface gbts_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [gbts_pkg::BYTE_W-1:0]           read_byte;
    logic [gbts_pkg::LEN_W-1:0]            text_length;
    logic [gbts_pkg::STS_W-1:0]            status;
    logic                                  changed;

    modport source (output valid, output read_byte, output text_length, output status,
                    output changed, input ready);
    modport sink   (input valid, input read_byte, input text_length, input status,
                    input changed, output ready);
endinterface

>>> rtl/core/gbts_ram.sv
// ----------------------------------------------------------------------------
// gbts_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/gbts_ctrl.sv
// ----------------------------------------------------------------------------
// gbts_ctrl
// Request sequencer: accept, check, move the gap, edit, hand out the result.
// ----------------------------------------------------------------------------
module gbts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  gbts_pkg::t_sts i_sts,
    output gbts_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_EDIT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.take_req = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.code != gbts_pkg::ST_DONE) begin
                    n_state = S_DONE;
                end else if (i_sts.is_read) begin
                    o_cmd.do_read = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (i_sts.at_pos) begin
                    n_state = S_EDIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_EDIT: begin
                // wait for the last copy write to drain
                if (!i_sts.wr_pend) begin
                    o_cmd.do_edit = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

>>> rtl/core/gbts_dp.sv
// ----------------------------------------------------------------------------
// gbts_dp
// Datapath: request latch, gap pointers, text memory, range checks, result.
// ----------------------------------------------------------------------------
module gbts_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbts_pkg::t_cmd                i_cmd,
    output gbts_pkg::t_sts                o_sts,
    input  logic [gbts_pkg::ACT_W-1:0]    i_action,
    input  logic [gbts_pkg::POS_W-1:0]    i_position,
    input  logic [gbts_pkg::BYTE_W-1:0]   i_new_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gbts_pkg::BYTE_W-1:0]   o_read_byte,
    output logic [gbts_pkg::LEN_W-1:0]    o_text_length,
    output logic [gbts_pkg::STS_W-1:0]    o_status,
    output logic                          o_changed
);

    // Request latch
    logic [gbts_pkg::ACT_W-1:0]  r_act;
    logic [gbts_pkg::POS_W-1:0]  r_pos;
    logic [gbts_pkg::BYTE_W-1:0] r_nb;
    logic [gbts_pkg::STS_W-1:0]  r_code;

    // Gap pointers and edit flag
    logic [gbts_pkg::PTR_W-1:0]  r_gb;
    logic [gbts_pkg::PTR_W-1:0]  r_gf;
    logic                        r_flag;

    // Delayed write of a gap copy step
    logic                        r_wr_pend;
    logic [gbts_pkg::ADDR_W-1:0] r_wr_addr;

    // Result register
    logic                        r_out_valid;
    logic [gbts_pkg::BYTE_W-1:0] r_out_byte;
    logic [gbts_pkg::LEN_W-1:0]  r_out_len;
    logic [gbts_pkg::STS_W-1:0]  r_out_sts;
    logic                        r_out_chg;

    logic [gbts_pkg::PTR_W-1:0]  gap;
    logic [gbts_pkg::PTR_W-1:0]  len;
    logic [gbts_pkg::CMP_W-1:0]  pos_c;
    logic [gbts_pkg::CMP_W-1:0]  len_c;
    logic [gbts_pkg::CMP_W-1:0]  gb_c;
    logic [gbts_pkg::STS_W-1:0]  code;
    logic                        gap_down;
    logic [gbts_pkg::PTR_W-1:0]  phys;
    logic [gbts_pkg::PTR_W-1:0]  gb_m1;
    logic [gbts_pkg::PTR_W-1:0]  gf_m1;

    logic                        ram_we;
    logic [gbts_pkg::ADDR_W-1:0] ram_waddr;
    logic [gbts_pkg::BYTE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [gbts_pkg::ADDR_W-1:0] ram_raddr;
    logic [gbts_pkg::BYTE_W-1:0] ram_rdata;
    logic                        edit_ins;

    // Length and compare operands
    assign gap   = r_gf - r_gb;
    assign len   = gbts_pkg::PTR_W'(gbts_pkg::STORE_BYTES) - gap;
    assign pos_c = gbts_pkg::CMP_W'(r_pos);
    assign len_c = gbts_pkg::CMP_W'(len);
    assign gb_c  = gbts_pkg::CMP_W'(r_gb);
    assign gb_m1 = r_gb - gbts_pkg::PTR_W'(1);
    assign gf_m1 = r_gf - gbts_pkg::PTR_W'(1);

    // Range and room checks per action
    always_comb begin
        code = gbts_pkg::ST_DONE;
        unique case (r_act)
            gbts_pkg::ACT_READ: begin
                if (pos_c >= len_c) code = gbts_pkg::ST_RANGE;
            end
            gbts_pkg::ACT_INSERT: begin
                if (gap < gbts_pkg::MIN_FREE_SLOTS) code = gbts_pkg::ST_NO_ROOM;
                else if (pos_c > len_c)             code = gbts_pkg::ST_RANGE;
            end
            gbts_pkg::ACT_DELETE: begin
                if (pos_c >= len_c) code = gbts_pkg::ST_RANGE;
            end
            gbts_pkg::ACT_BACKSPACE: begin
                if (r_pos == '0 || pos_c > len_c) code = gbts_pkg::ST_RANGE;
            end
            default: begin
                code = gbts_pkg::ST_DONE;
            end
        endcase
    end

    // Physical address of a logical position
    assign phys     = (pos_c < gb_c) ? gbts_pkg::PTR_W'(r_pos)
                                     : gbts_pkg::PTR_W'(r_pos) + gap;
    assign gap_down = (pos_c < gb_c);

    // Memory ports: copy writes have priority, edits wait for them
    assign edit_ins  = i_cmd.do_edit && (r_act == gbts_pkg::ACT_INSERT);
    assign ram_we    = r_wr_pend || edit_ins;
    assign ram_waddr = r_wr_pend ? r_wr_addr : r_gb[gbts_pkg::ADDR_W-1:0];
    assign ram_wdata = r_wr_pend ? ram_rdata : r_nb;
    assign ram_re    = i_cmd.step || i_cmd.do_read;
    always_comb begin
        if (i_cmd.step) begin
            ram_raddr = gap_down ? gb_m1[gbts_pkg::ADDR_W-1:0]
                                 : r_gf[gbts_pkg::ADDR_W-1:0];
        end else begin
            ram_raddr = phys[gbts_pkg::ADDR_W-1:0];
        end
    end

    gbts_ram #(
        .WIDTH (gbts_pkg::BYTE_W),
        .DEPTH (gbts_pkg::STORE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Request latch and status
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_act <= i_action;
            r_pos <= i_position;
            r_nb  <= i_new_byte;
        end
        if (i_cmd.eval) begin
            r_code <= code;
        end
    end

    // Gap pointers, copy write tracking, edit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gb      <= '0;
            r_gf      <= gbts_pkg::PTR_W'(gbts_pkg::STORE_BYTES);
            r_flag    <= 1'b0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.step;
            if (i_cmd.step) begin
                if (gap_down) begin
                    r_gb      <= gb_m1;
                    r_gf      <= gf_m1;
                    r_wr_addr <= gf_m1[gbts_pkg::ADDR_W-1:0];
                end else begin
                    r_gb      <= r_gb + gbts_pkg::PTR_W'(1);
                    r_gf      <= r_gf + gbts_pkg::PTR_W'(1);
                    r_wr_addr <= r_gb[gbts_pkg::ADDR_W-1:0];
                end
            end
            if (i_cmd.do_edit) begin
                r_flag <= 1'b1;
                case (r_act)
                    gbts_pkg::ACT_INSERT:    r_gb <= r_gb + gbts_pkg::PTR_W'(1);
                    gbts_pkg::ACT_DELETE:    r_gf <= r_gf + gbts_pkg::PTR_W'(1);
                    gbts_pkg::ACT_BACKSPACE: r_gb <= gb_m1;
                    default:                 r_gb <= r_gb;
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_byte <= (r_code == gbts_pkg::ST_DONE && r_act == gbts_pkg::ACT_READ)
                          ? ram_rdata : '0;
            r_out_len  <= (len_c > gbts_pkg::CMP_W'(gbts_pkg::LEN_MAX))
                          ? gbts_pkg::LEN_MAX : len_c[gbts_pkg::LEN_W-1:0];
            r_out_sts  <= r_code;
            r_out_chg  <= r_flag;
        end
    end

    // Status to the controller
    assign o_sts.code     = code;
    assign o_sts.is_read  = (r_act == gbts_pkg::ACT_READ);
    assign o_sts.at_pos   = (pos_c == gb_c);
    assign o_sts.wr_pend  = r_wr_pend;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_read_byte   = r_out_byte;
    assign o_text_length = r_out_len;
    assign o_status      = r_out_sts;
    assign o_changed     = r_out_chg;

endmodule

>>> rtl/core/gap_buffer_text_store.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Byte text store kept as a gap buffer in one single-port-pair memory.
// ----------------------------------------------------------------------------
// One request word in, one response word out. A read, and any refused request,
// goes from the check straight to the result stage. An edit first moves the gap
// until it begins at the request position, then applies the edit once the last
// gap copy write has drained, then goes to the result stage. The gap is moved
// one byte per cycle through the memory's one read and one write port, so the
// time of an edit grows with the distance between the request position and
// the current gap start. Edits close to the previous edit are therefore cheap.
// A response held off by the sink stalls the next request at its result stage.
// The store needs no clearing after reset. The next request is taken once the
// result is loaded, and so it is accepted while the previous response still
// waits to be taken.
module gap_buffer_text_store (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gbts_req_if.sink      i_req,
    gbts_rsp_if.source    o_rsp
);

    gbts_pkg::t_cmd cmd;
    gbts_pkg::t_sts sts;

    // Sequencer
    gbts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Storage and checks
    gbts_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_req.action),
        .i_position    (i_req.position),
        .i_new_byte    (i_req.new_byte),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_read_byte   (o_rsp.read_byte),
        .o_text_length (o_rsp.text_length),
        .o_status      (o_rsp.status),
        .o_changed     (o_rsp.changed)
    );

endmodule

>>> tb/gbts_text_checker.sv
// ----------------------------------------------------------------------------
// gbts_text_checker
// Watches the request and response channels of the gap buffer text store,
// keeps its own copy of the text as a byte queue, works out the response
// for every accepted request word and compares it with the response words
// in order.
// ----------------------------------------------------------------------------
module gbts_text_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gbts_req_if   i_req,
    gbts_rsp_if   i_rsp,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_text_len
);
    timeunit 1ns;
    timeprecision 1ps;

    import gbts_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [LEN_W-1:0]  text_length;
        logic [STS_W-1:0]  status;
        logic              changed;
    } t_rsp_word;

    // Logical text, front to back; the gap itself is not modeled
    logic [BYTE_W-1:0] text_q[$];
    // Responses owed by the block, oldest first
    t_rsp_word         owed_rsp_q[$];
    logic              edited     = 1'b0;
    int                fail_count = 0;
    int                owed_n     = 0;
    int                text_n     = 0;
    int                rsp_index  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = owed_n;
    assign o_text_len   = text_n;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: response %0d: %s", $time, rsp_index, msg);
        fail_count++;
    endtask

    // Applies one request to the text copy and returns the response it earns
    function automatic t_rsp_word apply_request(input logic [ACT_W-1:0]  act,
                                                input logic [POS_W-1:0]  pos,
                                                input logic [BYTE_W-1:0] nb);
        t_rsp_word r;
        int        len;
        int        p;
        r      = '0;
        len    = text_q.size();
        p      = int'(pos);
        case (act)
            ACT_READ: begin
                if (p < len) r.read_byte = text_q[p];
                else r.status = ST_RANGE;
            end
            ACT_INSERT: begin
                // room is checked ahead of the position
                if (STORE_BYTES - len < int'(MIN_FREE_SLOTS)) begin
                    r.status = ST_NO_ROOM;
                end else if (p > len) begin
                    r.status = ST_RANGE;
                end else begin
                    text_q.insert(p, nb);
                    edited = 1'b1;
                end
            end
            ACT_DELETE: begin
                if (p >= len) begin
                    r.status = ST_RANGE;
                end else begin
                    text_q.delete(p);
                    edited = 1'b1;
                end
            end
            ACT_BACKSPACE: begin
                if (p == 0 || p > len) begin
                    r.status = ST_RANGE;
                end else begin
                    text_q.delete(p - 1);
                    edited = 1'b1;
                end
            end
        endcase
        len           = text_q.size();
        r.text_length = (len > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(len);
        r.changed     = edited;
        return r;
    endfunction

    // Response compare first, then the new request: a response never
    // belongs to a request accepted at the same edge
    always @(posedge i_clk) begin
        t_rsp_word got;
        t_rsp_word want;
        if (!i_rst_n) begin
            text_q.delete();
            owed_rsp_q.delete();
            edited = 1'b0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.read_byte   = i_rsp.read_byte;
                got.text_length = i_rsp.text_length;
                got.status      = i_rsp.status;
                got.changed     = i_rsp.changed;
                if (owed_rsp_q.size() == 0) begin
                    report_mismatch("response word with none outstanding");
                end else begin
                    want = owed_rsp_q.pop_front();
                    if (got.read_byte !== want.read_byte)
                        report_mismatch($sformatf("read_byte %0h, expected %0h",
                                                  got.read_byte, want.read_byte));
                    if (got.text_length !== want.text_length)
                        report_mismatch($sformatf("text_length %0d, expected %0d",
                                                  got.text_length, want.text_length));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.changed !== want.changed)
                        report_mismatch($sformatf("changed %0b, expected %0b",
                                                  got.changed, want.changed));
                end
                rsp_index++;
            end
            if (i_req.valid && i_req.ready)
                owed_rsp_q.push_back(apply_request(i_req.action, i_req.position,
                                                   i_req.new_byte));
        end
        owed_n = owed_rsp_q.size();
        text_n = text_q.size();
    end

endmodule

>>> tb/gap_buffer_text_store_test.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store_test
// Drives request words into the gap buffer text store and takes its response
// words, with random idle cycles on both channels. A short directed run hits
// the empty-text and boundary cases, then a random run edits near a moving
// cursor with some out-of-range noise. Checking is done by gbts_text_checker.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbts_pkg::*;

    localparam int RANDOM_WORDS    = 1550;
    localparam int WATCHDOG_CYCLES = 4 * STORE_BYTES;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   text_len;
    bit   req_idle = 1'b1;
    bit   rsp_idle = 1'b1;

    gbts_req_if req_ch ();
    gbts_rsp_if rsp_ch ();

    gap_buffer_text_store DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    gbts_text_checker u_text_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_text_len   (text_len)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Starts and ends on a falling edge; returns once the word is taken
    task automatic send_word(input logic [ACT_W-1:0]  act,
                             input logic [POS_W-1:0]  pos,
                             input logic [BYTE_W-1:0] nb);
        int gap;
        gap = req_idle ? pick_gap() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.new_byte <= nb;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every owed response has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // Response side: random stalls between words
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = rsp_idle ? pick_gap() : 0;
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
            @(negedge i_clk);
        end
    end

    // Watchdog: ends the run after too long without any word moving
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** gap_buffer_text_store: FAILED **");
        $finish;
    end

    initial begin
        int               n;
        int               len;
        int               roll;
        int               p;
        int               cursor;
        logic [ACT_W-1:0] act;

        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_READ;
        req_ch.position = '0;
        req_ch.new_byte = '0;
        cursor          = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty text: everything but an insert at 0 is out of range
        send_word(ACT_READ,      16'd0,     8'h00);
        send_word(ACT_DELETE,    16'd0,     8'h00);
        send_word(ACT_BACKSPACE, 16'd0,     8'h00);
        send_word(ACT_BACKSPACE, 16'd1,     8'h00);
        send_word(ACT_INSERT,    16'd1,     8'h11);
        send_word(ACT_INSERT,    16'hFFFF,  8'h22);
        // Build a short text, inserting at end and front
        send_word(ACT_INSERT,    16'd0,     8'h00);
        send_word(ACT_INSERT,    16'd1,     8'hFF);
        send_word(ACT_INSERT,    16'd0,     8'hA5);
        send_word(ACT_INSERT,    16'd3,     8'h5A);
        send_word(ACT_READ,      16'd0,     8'hFF);
        send_word(ACT_READ,      16'd1,     8'h00);
        send_word(ACT_READ,      16'd2,     8'h00);
        send_word(ACT_READ,      16'd3,     8'h00);
        send_word(ACT_READ,      16'd4,     8'h00);
        send_word(ACT_READ,      16'hFFFF,  8'h00);
        // Deletes and backspaces at the text edges
        send_word(ACT_DELETE,    16'd4,     8'h00);
        send_word(ACT_DELETE,    16'd3,     8'h00);
        send_word(ACT_DELETE,    16'd0,     8'h00);
        send_word(ACT_BACKSPACE, 16'd3,     8'h00);
        send_word(ACT_BACKSPACE, 16'hFFFF,  8'h00);
        send_word(ACT_BACKSPACE, 16'd2,     8'h00);
        send_word(ACT_READ,      16'd0,     8'h00);
        drain_results();

        // Random edits around a cursor, text kept between about 16 and 400 bytes
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 128 == 0) begin
                roll     = $urandom_range(0, 3);
                req_idle = roll[0];
                rsp_idle = roll[1];
            end
            if (n % 400 == 399) drain_results();
            len = text_len;
            act = ACT_W'($urandom_range(0, 3));
            if (len < 16 && $urandom_range(0, 1) == 1) act = ACT_INSERT;
            if (len > 400 && act == ACT_INSERT) act = ACT_DELETE;
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                p = $urandom_range(0, 65535);
            end else if (roll < 20) begin
                case ($urandom_range(0, 3))
                    0: p = 0;
                    1: p = len;
                    2: p = (len > 0) ? len - 1 : 0;
                    default: p = len + 1;
                endcase
            end else if (roll < 30) begin
                p = $urandom_range(0, len);
            end else begin
                p = cursor + $urandom_range(0, 8) - 4;
                if (p < 0) p = 0;
                if (p > len) p = len;
            end
            send_word(act, POS_W'(p), BYTE_W'($urandom_range(0, 255)));
            if (act != ACT_READ && p <= len) cursor = p;
        end
        drain_results();

        repeat (16) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** gap_buffer_text_store: PASSED **");
        else
            $display("** gap_buffer_text_store: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/gbts_pkg.sv
rtl/core/gbts_if.sv
rtl/core/gbts_ram.sv
rtl/core/gbts_ctrl.sv
rtl/core/gbts_dp.sv
rtl/core/gap_buffer_text_store.sv
tb/gbts_text_checker.sv
tb/gap_buffer_text_store_test.sv
